// ----- src/tct_pkg.sv -----
package tct_pkg;

	localparam int MaxContacts = 16;
	localparam int IdxBits     = $clog2(MaxContacts);
	localparam int CountBits   = $clog2(MaxContacts + 1);
	localparam int TagBits     = 32;
	localparam int CoordBits   = 16;
	localparam int DeltaBits   = CoordBits + 1;
	localparam int ButtonBits  = 5;
	localparam int KindBits    = 2;
	localparam int StatusBits  = 2;

	localparam logic [ButtonBits-1:0] ButtonMax = '1;

	localparam logic [KindBits-1:0] KIND_BEGIN  = 2'd0;
	localparam logic [KindBits-1:0] KIND_UPDATE = 2'd1;
	localparam logic [KindBits-1:0] KIND_FINISH = 2'd2;
	localparam logic [KindBits-1:0] KIND_NONE   = 2'd3;

	localparam logic [StatusBits-1:0] ST_OK      = 2'd0;
	localparam logic [StatusBits-1:0] ST_UNKNOWN = 2'd1;
	localparam logic [StatusBits-1:0] ST_FULL    = 2'd2;

	typedef struct packed {
		logic capture;
		logic lookup;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic void_kind;
	} sts_t;

endpackage

// ----- src/touch_contact_tracker.sv -----
// Tracks up to 16 touch contacts by 32-bit tag and hands each a button number taken from a
// LIFO free stack or from a rising top counter. Every begin, update or finish item yields one
// result with status, button, stored position and motion (old minus new); kind 3 is dropped
// with no result. One item is in flight at a time: an item passes through capture, parallel
// tag search and state commit before its result is valid, and the result then waits for
// out_ready; a dropped item frees the input after the tag search. The table needs no
// clearing pass after reset.
module touch_contact_tracker (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic        [tct_pkg::KindBits-1:0]    kind,
	input  logic        [tct_pkg::TagBits-1:0]     contact_tag,
	input  logic signed [tct_pkg::CoordBits-1:0]   pos_x,
	input  logic signed [tct_pkg::CoordBits-1:0]   pos_y,
	input  logic signed [tct_pkg::CoordBits-1:0]   pos_z,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic        [tct_pkg::StatusBits-1:0]  status,
	output logic        [tct_pkg::ButtonBits-1:0]  button,
	output logic signed [tct_pkg::CoordBits-1:0]   out_x,
	output logic signed [tct_pkg::CoordBits-1:0]   out_y,
	output logic signed [tct_pkg::CoordBits-1:0]   out_z,
	output logic signed [tct_pkg::DeltaBits-1:0]   delta_x,
	output logic signed [tct_pkg::DeltaBits-1:0]   delta_y,
	output logic signed [tct_pkg::DeltaBits-1:0]   delta_z
);

	tct_pkg::cmd_t cmd;
	tct_pkg::sts_t sts;

	tct_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	tct_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.kind        (kind),
		.contact_tag (contact_tag),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.pos_z       (pos_z),
		.status      (status),
		.button      (button),
		.out_x       (out_x),
		.out_y       (out_y),
		.out_z       (out_z),
		.delta_x     (delta_x),
		.delta_y     (delta_y),
		.delta_z     (delta_z)
	);

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input taken while a result is pending");

	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !out_valid)
		else $error("result shown right after accept");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != tct_pkg::ST_OK |->
		button == '0 && delta_x == '0 && delta_y == '0 && delta_z == '0 && out_x == '0)
		else $error("error result carries nonzero fields");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(button))
		else $error("pending result changed");

endmodule

// ----- src/tct_ctrl.sv -----
module tct_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output tct_pkg::cmd_t cmd,
	input  tct_pkg::sts_t sts
);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_LOOKUP = 4'b0010,
		S_COMMIT = 4'b0100,
		S_OUT    = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		in_ready    = 1'b0;
		out_valid   = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
				if (in_valid) begin
					state_d = S_LOOKUP;
				end
			end
			S_LOOKUP: begin
				cmd.lookup = 1'b1;
				state_d    = sts.void_kind ? S_IDLE : S_COMMIT;
			end
			S_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = S_OUT;
			end
			S_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- src/tct_dpath.sv -----
module tct_dpath (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  tct_pkg::cmd_t                           cmd,
	output tct_pkg::sts_t                           sts,
	input  logic        [tct_pkg::KindBits-1:0]     kind,
	input  logic        [tct_pkg::TagBits-1:0]      contact_tag,
	input  logic signed [tct_pkg::CoordBits-1:0]    pos_x,
	input  logic signed [tct_pkg::CoordBits-1:0]    pos_y,
	input  logic signed [tct_pkg::CoordBits-1:0]    pos_z,
	output logic        [tct_pkg::StatusBits-1:0]   status,
	output logic        [tct_pkg::ButtonBits-1:0]   button,
	output logic signed [tct_pkg::CoordBits-1:0]    out_x,
	output logic signed [tct_pkg::CoordBits-1:0]    out_y,
	output logic signed [tct_pkg::CoordBits-1:0]    out_z,
	output logic signed [tct_pkg::DeltaBits-1:0]    delta_x,
	output logic signed [tct_pkg::DeltaBits-1:0]    delta_y,
	output logic signed [tct_pkg::DeltaBits-1:0]    delta_z
);

	localparam int N  = tct_pkg::MaxContacts;
	localparam int IB = tct_pkg::IdxBits;
	localparam int CB = tct_pkg::CoordBits;
	localparam int DB = tct_pkg::DeltaBits;
	localparam int BB = tct_pkg::ButtonBits;
	localparam int NB = tct_pkg::CountBits;

	logic [tct_pkg::KindBits-1:0] kind_q;
	logic [tct_pkg::TagBits-1:0]  tag_q;
	logic signed [CB-1:0]         new_q [3];

	logic                        entry_valid_q [N];
	logic [tct_pkg::TagBits-1:0] entry_tag_q   [N];
	logic [BB-1:0]               entry_button_q[N];
	logic signed [CB-1:0]        entry_pos_q   [N][3];
	logic [BB-1:0]               free_stack_q  [N];
	logic [NB-1:0]               free_count_q;
	logic [BB-1:0]               top_q;

	logic          hit_c, free_ok_c;
	logic [IB-1:0] hit_idx_c, free_idx_c;
	logic          hit_s1, free_ok_s1;
	logic [IB-1:0] hit_idx_s1, free_idx_s1;

	always_comb begin
		hit_c      = 1'b0;
		free_ok_c  = 1'b0;
		hit_idx_c  = '0;
		free_idx_c = '0;
		for (int i = N - 1; i >= 0; i--) begin
			if (entry_valid_q[i] && entry_tag_q[i] == tag_q) begin
				hit_c     = 1'b1;
				hit_idx_c = IB'(i);
			end
			if (!entry_valid_q[i]) begin
				free_ok_c  = 1'b1;
				free_idx_c = IB'(i);
			end
		end
	end

	assign sts.void_kind = (kind_q == tct_pkg::KIND_NONE);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q   <= kind;
			tag_q    <= contact_tag;
			new_q[0] <= pos_x;
			new_q[1] <= pos_y;
			new_q[2] <= pos_z;
		end
		if (cmd.lookup) begin
			hit_s1      <= hit_c;
			hit_idx_s1  <= hit_idx_c;
			free_ok_s1  <= free_ok_c;
			free_idx_s1 <= free_idx_c;
		end
	end

	logic                 is_begin, is_finish;
	logic [IB-1:0]        wr_idx;
	logic                 pop;
	logic [IB-1:0]        pop_idx;
	logic [BB-1:0]        begin_b, old_b;
	logic                 begin_ok, move_ok;
	logic                 do_begin, do_move, do_release;
	logic                 dec_top, push;
	logic signed [DB-1:0] diff [3];

	always_comb begin
		is_begin   = (kind_q == tct_pkg::KIND_BEGIN);
		is_finish  = (kind_q == tct_pkg::KIND_FINISH);
		wr_idx     = hit_s1 ? hit_idx_s1 : free_idx_s1;
		pop        = (free_count_q != '0);
		pop_idx    = IB'(free_count_q - NB'(1));
		begin_b    = pop ? free_stack_q[pop_idx] : top_q + BB'(1);
		old_b      = entry_button_q[hit_idx_s1];
		begin_ok   = (hit_s1 || free_ok_s1) && (pop || top_q != tct_pkg::ButtonMax);
		move_ok    = hit_s1;
		do_begin   = cmd.commit && is_begin && begin_ok;
		do_move    = cmd.commit && !is_begin && move_ok;
		do_release = do_move && is_finish;
		dec_top    = do_release && (old_b == top_q);
		push       = do_release && !dec_top && (free_count_q < NB'(N));
		for (int j = 0; j < 3; j++) begin
			diff[j] = DB'(entry_pos_q[hit_idx_s1][j]) - DB'(new_q[j]);
		end
	end

	always_ff @(posedge clk) begin
		if (do_begin) begin
			entry_tag_q[wr_idx]    <= tag_q;
			entry_button_q[wr_idx] <= begin_b;
			for (int j = 0; j < 3; j++) begin
				entry_pos_q[wr_idx][j] <= new_q[j];
			end
		end
		if (do_move) begin
			for (int j = 0; j < 3; j++) begin
				entry_pos_q[hit_idx_s1][j] <= new_q[j];
			end
		end
		if (push) begin
			free_stack_q[IB'(free_count_q)] <= old_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N; i++) begin
				entry_valid_q[i] <= 1'b0;
			end
			free_count_q <= '0;
			top_q        <= '0;
		end else begin
			if (do_begin) begin
				entry_valid_q[wr_idx] <= 1'b1;
				if (pop) begin
					free_count_q <= free_count_q - NB'(1);
				end else begin
					top_q <= top_q + BB'(1);
				end
			end
			if (do_release) begin
				entry_valid_q[hit_idx_s1] <= 1'b0;
			end
			if (dec_top) begin
				top_q <= top_q - BB'(1);
			end
			if (push) begin
				free_count_q <= free_count_q + NB'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status  <= tct_pkg::ST_OK;
			button  <= '0;
			out_x   <= '0;
			out_y   <= '0;
			out_z   <= '0;
			delta_x <= '0;
			delta_y <= '0;
			delta_z <= '0;
			if (is_begin) begin
				if (begin_ok) begin
					button <= begin_b;
					out_x  <= new_q[0];
					out_y  <= new_q[1];
					out_z  <= new_q[2];
				end else begin
					status <= tct_pkg::ST_FULL;
				end
			end else if (move_ok) begin
				button  <= old_b;
				out_x   <= new_q[0];
				out_y   <= new_q[1];
				out_z   <= new_q[2];
				delta_x <= diff[0];
				delta_y <= diff[1];
				delta_z <= diff[2];
			end else begin
				status <= tct_pkg::ST_UNKNOWN;
			end
		end
	end

endmodule
